// ===== src/mdsg_pkg.sv =====
// Shared types and constants of the four-axis DDA step generator.
// Used by the channel interfaces, the controller, the datapath and the top level.
package mdsg_pkg;

    // Sizes of the axis set and of the per-tick iteration budget.
    localparam int AXES       = 4;
    localparam int MAX_LOOPS  = 4;
    localparam int CNT_W      = (MAX_LOOPS > 1) ? $clog2(MAX_LOOPS) : 1;

    // Field widths.
    localparam int STEP_W     = 24;
    localparam int EVT_W      = 24;
    localparam int DONE_W     = 25;
    localparam int ACC_W      = 26;
    localparam int POS_W      = 32;
    localparam int PIN_W      = 4;
    localparam int HIT_W      = 3;
    localparam int LOOPS_W    = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Request opcodes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ENDSTOP_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ENDSTOP_INVERT = CFG_IDX_W'(1);

    // Endstop pin positions and axis positions.
    localparam int PIN_X_MAX = 0;
    localparam int PIN_Y_MAX = 1;
    localparam int PIN_Z_MIN = 2;
    localparam int PIN_Z_MAX = 3;
    localparam int AX_X      = 0;
    localparam int AX_Y      = 1;
    localparam int AX_Z      = 2;

    // Input request payload as seen by the datapath.
    typedef struct packed {
        logic [AXES-1:0][STEP_W-1:0] steps;
        logic [EVT_W-1:0]            event_count;
        logic [AXES-1:0]             dir_bits;
        logic [PIN_W-1:0]            endstop_levels;
    } t_in_item;

    // Result payload held in the output register.
    typedef struct packed {
        logic [AXES-1:0]            step_mask;
        logic [AXES-1:0]            dir_mask;
        logic [HIT_W-1:0]           hit_mask;
        logic                       block_done;
        logic                       last;
        logic [AXES-1:0][POS_W-1:0] pos;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic check;
        logic iter;
        logic last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;
        logic iter_done;
    } t_dp_stat;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_ITER
    } t_state;

endpackage

// ===== src/mdsg_if.sv =====
// Channel interfaces of the DDA step generator: input requests, results, config writes.
// Depends on mdsg_pkg for field widths.
interface mdsg_in_if
    import mdsg_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                op;
    logic [STEP_W-1:0]   steps_x;
    logic [STEP_W-1:0]   steps_y;
    logic [STEP_W-1:0]   steps_z;
    logic [STEP_W-1:0]   steps_e;
    logic [EVT_W-1:0]    event_count;
    logic [AXES-1:0]     dir_bits;
    logic [PIN_W-1:0]    endstop_levels;
    logic [LOOPS_W-1:0]  loops;

    modport source (
        output valid, op, steps_x, steps_y, steps_z, steps_e, event_count,
               dir_bits, endstop_levels, loops,
        input  ready
    );
    modport sink (
        input  valid, op, steps_x, steps_y, steps_z, steps_e, event_count,
               dir_bits, endstop_levels, loops,
        output ready
    );
endinterface

interface mdsg_out_if
    import mdsg_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [AXES-1:0]         step_mask;
    logic [AXES-1:0]         dir_mask;
    logic [HIT_W-1:0]        hit_mask;
    logic                    block_done;
    logic                    last;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [POS_W-1:0] pos_e;

    modport source (
        output valid, step_mask, dir_mask, hit_mask, block_done, last,
               pos_x, pos_y, pos_z, pos_e,
        input  ready
    );
    modport sink (
        input  valid, step_mask, dir_mask, hit_mask, block_done, last,
               pos_x, pos_y, pos_z, pos_e,
        output ready
    );
endinterface

interface mdsg_cfg_if
    import mdsg_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/mdsg_datapath.sv =====
// Datapath of the DDA step generator: block state, endstop check, one DDA iteration,
// configuration registers and the result register. Depends on mdsg_pkg and mdsg_cfg_if.
module mdsg_datapath
    import mdsg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  t_in_item    i_item,
    mdsg_cfg_if.sink    i_cfg,
    output t_dp_stat    o_stat,
    output t_out_item   o_res
);

    // Configuration registers.
    logic                r_es_enable;
    logic [PIN_W-1:0]    r_es_invert;

    // Block state.
    logic                        r_active;
    logic [AXES-1:0][STEP_W-1:0] r_steps;
    logic [EVT_W-1:0]            r_total;
    logic [AXES-1:0]             r_dirs;
    logic [AXES-1:0][ACC_W-1:0]  r_err;
    logic [DONE_W-1:0]           r_done_cnt;
    logic [AXES-1:0][POS_W-1:0]  r_pos;
    logic [PIN_W-1:0]            r_prev_es;
    logic [HIT_W-1:0]            r_hit;
    t_out_item                   r_res;

    // Iteration results.
    logic [AXES-1:0][ACC_W-1:0]  n_err_it;
    logic [AXES-1:0][POS_W-1:0]  n_pos_it;
    logic [AXES-1:0]             smask;
    logic [DONE_W-1:0]           n_done_it;
    logic                        iter_done;

    // Endstop check results.
    logic [PIN_W-1:0]  trig;
    logic [PIN_W-1:0]  checked;
    logic [PIN_W-1:0]  fire;
    logic [HIT_W-1:0]  n_hit_chk;
    logic [PIN_W-1:0]  n_prev_chk;
    logic [ACC_W-1:0]  err_preset;

    assign i_cfg.ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_es_enable <= 1'b1;
            r_es_invert <= '1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ENDSTOP_ENABLE: r_es_enable <= i_cfg.data[0];
                REG_ENDSTOP_INVERT: r_es_invert <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // One Bresenham iteration over all axes; the axes are independent.
    always_comb begin
        logic [ACC_W-1:0] sum;
        for (int a = 0; a < AXES; a++) begin
            sum = r_err[a] + ACC_W'(r_steps[a]);
            if (!sum[ACC_W-1] && (sum != '0)) begin
                n_err_it[a] = sum - ACC_W'(r_total);
                smask[a]    = 1'b1;
                n_pos_it[a] = r_dirs[a] ? (r_pos[a] - POS_W'(1)) : (r_pos[a] + POS_W'(1));
            end else begin
                n_err_it[a] = sum;
                smask[a]    = 1'b0;
                n_pos_it[a] = r_pos[a];
            end
        end
        n_done_it = r_done_cnt + DONE_W'(1);
        iter_done = (n_done_it >= DONE_W'(r_total));
    end

    // Endstop check in the direction of travel, debounced over two checks.
    always_comb begin
        trig                = i_item.endstop_levels ^ r_es_invert;
        checked[PIN_X_MAX]  = r_es_enable & ~r_dirs[AX_X];
        checked[PIN_Y_MAX]  = r_es_enable & ~r_dirs[AX_Y];
        checked[PIN_Z_MIN]  = r_es_enable &  r_dirs[AX_Z];
        checked[PIN_Z_MAX]  = r_es_enable & ~r_dirs[AX_Z];
        fire[PIN_X_MAX]     = (r_steps[AX_X] != '0);
        fire[PIN_Y_MAX]     = (r_steps[AX_Y] != '0);
        fire[PIN_Z_MIN]     = (r_steps[AX_Z] != '0);
        fire[PIN_Z_MAX]     = (r_steps[AX_Z] != '0);
        fire                = fire & checked & trig & r_prev_es;
        n_hit_chk           = r_hit;
        n_hit_chk[AX_X]     = r_hit[AX_X] | fire[PIN_X_MAX];
        n_hit_chk[AX_Y]     = r_hit[AX_Y] | fire[PIN_Y_MAX];
        n_hit_chk[AX_Z]     = r_hit[AX_Z] | fire[PIN_Z_MIN] | fire[PIN_Z_MAX];
        n_prev_chk          = (r_prev_es & ~checked) | (trig & checked);
        err_preset          = ACC_W'(0) - ACC_W'(i_item.event_count >> 1);
    end

    // Block state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_dirs     <= '0;
            r_err      <= '0;
            r_done_cnt <= '0;
            r_pos      <= '0;
            r_prev_es  <= '0;
            r_hit      <= '0;
        end else if (i_cmd.load) begin
            r_active   <= 1'b1;
            r_dirs     <= i_item.dir_bits;
            r_err      <= {AXES{err_preset}};
            r_done_cnt <= '0;
            r_hit      <= '0;
        end else if (i_cmd.check) begin
            r_hit      <= n_hit_chk;
            r_prev_es  <= n_prev_chk;
            if (fire != '0) begin
                r_done_cnt <= DONE_W'(r_total);
            end
        end else if (i_cmd.iter) begin
            r_err      <= n_err_it;
            r_pos      <= n_pos_it;
            r_done_cnt <= n_done_it;
            if (iter_done) begin
                r_active <= 1'b0;
            end
        end
    end

    // Step counts and the result register hold payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_steps <= i_item.steps;
            r_total <= i_item.event_count;
        end
        if (i_cmd.iter) begin
            r_res.step_mask  <= smask;
            r_res.dir_mask   <= r_dirs;
            r_res.hit_mask   <= r_hit;
            r_res.block_done <= iter_done;
            r_res.last       <= i_cmd.last;
            r_res.pos        <= n_pos_it;
        end
    end

    assign o_stat.active    = r_active;
    assign o_stat.iter_done = iter_done;
    assign o_res            = r_res;

endmodule

// ===== src/mdsg_ctrl.sv =====
// Controller of the DDA step generator: request intake, iteration count and result valid.
// Depends on mdsg_pkg and mdsg_in_if; drives the datapath through t_dp_cmd.
module mdsg_ctrl
    import mdsg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mdsg_in_if.sink   i_in,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    input  t_dp_stat  i_stat,
    output t_dp_cmd   o_cmd
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_last_idx, n_last_idx;
    logic               r_out_valid, n_out_valid;
    logic               in_accept;
    logic               can_issue;
    logic [CNT_W-1:0]   loops_idx;

    // Iteration budget of a tick: zero counts as one, large values saturate.
    always_comb begin
        if (i_in.loops == '0) begin
            loops_idx = '0;
        end else if (int'(i_in.loops) > MAX_LOOPS) begin
            loops_idx = CNT_W'(MAX_LOOPS - 1);
        end else begin
            loops_idx = CNT_W'(i_in.loops - LOOPS_W'(1));
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_last_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_last_idx  <= n_last_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_last_idx  = r_last_idx;
        o_cmd       = '0;
        i_in.ready  = 1'b0;
        in_accept   = 1'b0;
        can_issue   = !r_out_valid || i_out_ready;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                in_accept  = i_in.valid;
                if (in_accept && (i_in.op == OP_LOAD)) begin
                    o_cmd.load = 1'b1;
                end else if (in_accept && i_stat.active) begin
                    o_cmd.check = 1'b1;
                    n_cnt       = '0;
                    n_last_idx  = loops_idx;
                    n_state     = ST_ITER;
                end
            end
            ST_ITER: begin
                if (can_issue) begin
                    o_cmd.iter  = 1'b1;
                    o_cmd.last  = i_stat.iter_done || (r_cnt == r_last_idx);
                    n_out_valid = 1'b1;
                    if (o_cmd.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/multi_axis_dda_step_generator_top.sv =====
// Top level of the four-axis Bresenham DDA step generator.
// Depends on mdsg_pkg, mdsg_if, mdsg_ctrl and mdsg_datapath.
//
//   Channel  Port    Direction  Payload
//   -------  ------  ---------  --------------------------------------------------
//   input    i_in    sink       op, four step counts, event count, dirs, pins, loops
//   result   o_out   source     step, dir and hit masks, done, last, four positions
//   config   i_cfg   sink       register index and write data
//
// A load request gives no result. A tick on an active block first runs the endstop check
// and then one DDA iteration per result, n results in all (n at most MAX_LOOPS, fewer
// once the block is done).
// Reset (i_rst_n, synchronous, active low) idles the block and clears positions.
// A stalled result register holds the next iteration back; a new request is taken
// while the final result of the previous one still waits.
module multi_axis_dda_step_generator_top
    import mdsg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mdsg_in_if.sink    i_in,
    mdsg_out_if.source o_out,
    mdsg_cfg_if.sink   i_cfg
);

    t_dp_cmd   cmd;
    t_dp_stat  stat;
    t_in_item  item;
    t_out_item res;
    logic      out_valid;

    // Gather the input fields for the datapath.
    assign item.steps          = {i_in.steps_e, i_in.steps_z, i_in.steps_y, i_in.steps_x};
    assign item.event_count    = i_in.event_count;
    assign item.dir_bits       = i_in.dir_bits;
    assign item.endstop_levels = i_in.endstop_levels;

    mdsg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mdsg_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (item),
        .i_cfg   (i_cfg),
        .o_stat  (stat),
        .o_res   (res)
    );

    // Result channel.
    assign o_out.valid      = out_valid;
    assign o_out.step_mask  = res.step_mask;
    assign o_out.dir_mask   = res.dir_mask;
    assign o_out.hit_mask   = res.hit_mask;
    assign o_out.block_done = res.block_done;
    assign o_out.last       = res.last;
    assign o_out.pos_x      = res.pos[AX_X];
    assign o_out.pos_y      = res.pos[AX_Y];
    assign o_out.pos_z      = res.pos[AX_Z];
    assign o_out.pos_e      = res.pos[AXES-1];

endmodule
